### rtl/core/hhls_pkg.sv
// ----------------------------------------------------------------------------
// hhls_pkg
// Types and constants shared by the header line scanner files.
// ----------------------------------------------------------------------------
package hhls_pkg;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned LINE_W   = 13;
  localparam int unsigned LINENO_W = 8;
  localparam int unsigned TP_W     = 3;

  localparam logic [POS_W-1:0]    MAX_HEADER_BYTES = 16'hFFFF;
  localparam logic [LINE_W-1:0]   MAX_LINE_BYTES   = 13'h1FFF;
  localparam logic [LINENO_W-1:0] MAX_LINES        = 8'hFF;

  // position of the final LF when the terminator starts at byte zero
  localparam logic [POS_W-1:0] TERM_AT_ZERO_POS = 16'd3;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // terminator match progress
  localparam logic [TP_W-1:0] TP_NONE  = 3'd0;
  localparam logic [TP_W-1:0] TP_CR    = 3'd1;
  localparam logic [TP_W-1:0] TP_CR_LF = 3'd2;
  localparam logic [TP_W-1:0] TP_DONE  = 3'd4;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_DONE    = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
  } in_item_t;

  typedef struct packed {
    result_kind_e        result_kind;
    logic [LINENO_W-1:0] line_index;
    logic [LINE_W-1:0]   line_length;
    logic                colon_found;
    logic [LINE_W-1:0]   key_begin;
    logic [LINE_W-1:0]   key_end;
    logic [LINE_W-1:0]   val_begin;
    logic [LINE_W-1:0]   val_end;
    logic [POS_W-1:0]    header_bytes;
    logic                no_lines;
    logic                overflow;
  } result_t;

  typedef struct packed {
    logic done;
    logic pending;
    logic skip;
  } scan_status_t;

endpackage

### rtl/core/hhls_byte_if.sv
// ----------------------------------------------------------------------------
// hhls_byte_if
// Request byte channel: valid/ready with one byte and a start flag.
// ----------------------------------------------------------------------------
interface hhls_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_message;

  modport source (output valid, output data_byte, output start_of_message, input ready);
  modport sink   (input valid, input data_byte, input start_of_message, output ready);
endinterface

### rtl/core/hhls_result_if.sv
// ----------------------------------------------------------------------------
// hhls_result_if
// Result channel: valid/ready with one line descriptor or end result.
// ----------------------------------------------------------------------------
interface hhls_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  line_index;
  logic [12:0] line_length;
  logic        colon_found;
  logic [12:0] key_begin;
  logic [12:0] key_end;
  logic [12:0] val_begin;
  logic [12:0] val_end;
  logic [15:0] header_bytes;
  logic        no_lines;
  logic        overflow;

  modport source (
    output valid, output result_kind, output line_index, output line_length,
    output colon_found, output key_begin, output key_end, output val_begin,
    output val_end, output header_bytes, output no_lines, output overflow,
    input ready
  );
  modport sink (
    input valid, input result_kind, input line_index, input line_length,
    input colon_found, input key_begin, input key_end, input val_begin,
    input val_end, input header_bytes, input no_lines, input overflow,
    output ready
  );
endinterface

### rtl/core/hhls_in_stage.sv
// ----------------------------------------------------------------------------
// hhls_in_stage
// Input register: holds one byte until the scanner steps on it.
// ----------------------------------------------------------------------------
module hhls_in_stage import hhls_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  hhls_byte_if.sink       byte_i,
  input  logic            step_i,
  output logic            item_valid_o,
  output in_item_t        item_o
);

  logic     valid_q;
  in_item_t item_q;
  logic     xfer;

  assign byte_i.ready = !valid_q || step_i;
  assign xfer         = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (xfer) begin
      valid_q <= 1'b1;
    end else if (step_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      item_q.data_byte        <= byte_i.data_byte;
      item_q.start_of_message <= byte_i.start_of_message;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/core/hhls_scan.sv
// ----------------------------------------------------------------------------
// hhls_scan
// Running line and terminator state, updated once per byte.
// ----------------------------------------------------------------------------
module hhls_scan import hhls_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  in_item_t     item_i,
  output logic         produce_o,
  output result_t      result_o,
  output scan_status_t status_o
);

  typedef struct packed {
    logic [LINE_W-1:0] offset;
    logic              colon;
    logic [LINE_W-1:0] kfn;
    logic [LINE_W-1:0] kln;
    logic [LINE_W-1:0] vfn;
    logic [LINE_W-1:0] vln;
  } line_t;

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [TP_W-1:0]     tp;
    line_t               line;
    logic [LINENO_W-1:0] line_no;
    logic                skip;
    logic                pending;
    logic                done;
    logic                sat;
    logic                emit_due;
  } state_t;

  state_t st_q, st_d;

  function automatic result_t emit_desc(line_t l, logic [LINENO_W-1:0] n);
    result_t r;
    r = '0;
    r.result_kind = (n == '0) ? KIND_REQUEST : KIND_HEADER;
    r.line_index  = n;
    r.line_length = l.offset;
    if (n != '0) begin
      r.colon_found = l.colon;
      r.val_begin   = l.offset;
      r.val_end     = l.offset;
      if (l.colon) begin
        r.key_begin = l.kfn;
        r.key_end   = l.kln;
        if (l.vln != '0) begin
          r.val_begin = l.vfn;
          r.val_end   = l.vln;
        end
      end else if (l.kln == '0) begin
        r.key_begin = l.offset;
        r.key_end   = l.offset;
      end else begin
        r.key_begin = l.kfn;
        r.key_end   = l.kln;
      end
    end
    return r;
  endfunction

  always_comb begin
    state_t            s;
    line_t             l;
    logic [7:0]        b;
    logic [7:0]        want_ch;
    logic [TP_W-1:0]   prev;
    logic [TP_W-1:0]   tp_n;
    logic [POS_W-1:0]  p;
    logic [LINE_W-1:0] off;
    logic [LINE_W-1:0] off_inc;
    logic              blank;

    b         = item_i.data_byte;
    s         = item_i.start_of_message ? state_t'('0) : st_q;
    st_d      = s;
    result_o  = '0;
    produce_o = 1'b0;
    l         = '0;
    off       = '0;
    off_inc   = '0;
    blank     = 1'b0;
    p         = s.pos;
    prev      = s.tp;
    want_ch   = prev[0] ? CH_LF : CH_CR;
    tp_n      = (b == want_ch) ? prev + TP_W'(1) : ((b == CH_CR) ? TP_CR : TP_NONE);

    if (!s.done) begin
      if (p == MAX_HEADER_BYTES) begin
        st_d.sat = 1'b1;
      end else begin
        st_d.pos = p + POS_W'(1);
      end
      st_d.tp = tp_n;

      if (tp_n == TP_DONE) begin
        st_d.done             = 1'b1;
        st_d.tp               = TP_NONE;
        result_o.result_kind  = KIND_DONE;
        result_o.header_bytes = st_d.pos;
        result_o.no_lines     = (p == TERM_AT_ZERO_POS);
        produce_o             = 1'b1;
      end else if (s.skip) begin
        st_d.skip = 1'b0;
        if (s.pending) begin
          st_d.pending = 1'b0;
          result_o     = emit_desc(s.line, s.line_no);
          produce_o    = 1'b1;
          if (s.line_no == MAX_LINES) begin
            st_d.sat = 1'b1;
          end else begin
            st_d.line_no = s.line_no + LINENO_W'(1);
          end
        end
      end else begin
        if (s.emit_due) begin
          st_d.emit_due = 1'b0;
          if (s.line.offset == '0 && prev == TP_CR_LF && b == CH_CR) begin
            st_d.pending = 1'b1;
          end else begin
            result_o  = emit_desc(s.line, s.line_no);
            produce_o = 1'b1;
            if (s.line_no == MAX_LINES) begin
              st_d.sat = 1'b1;
            end else begin
              st_d.line_no = s.line_no + LINENO_W'(1);
            end
          end
          st_d.line = '0;
        end

        if (b == CH_CR) begin
          st_d.skip     = 1'b1;
          st_d.emit_due = 1'b1;
        end else begin
          l       = st_d.line;
          off     = l.offset;
          blank   = (b == CH_SPACE) || (b == CH_TAB);
          off_inc = (off == MAX_LINE_BYTES) ? off : off + LINE_W'(1);
          if (off == MAX_LINE_BYTES) begin
            st_d.sat = 1'b1;
          end
          st_d.line.offset = off_inc;
          if (!l.colon) begin
            if (b == CH_COLON) begin
              st_d.line.colon = 1'b1;
              if (l.kln == '0) begin
                st_d.line.kfn = off;
                st_d.line.kln = off;
              end
            end else if (!blank) begin
              if (l.kln == '0) begin
                st_d.line.kfn = off;
              end
              st_d.line.kln = off_inc;
            end
          end else if (!blank) begin
            if (l.vln == '0) begin
              st_d.line.vfn = off;
            end
            st_d.line.vln = off_inc;
          end
        end
      end
      result_o.overflow = st_d.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign status_o = '{done: st_q.done, pending: st_q.pending, skip: st_q.skip};

endmodule

### rtl/core/hhls_out_stage.sv
// ----------------------------------------------------------------------------
// hhls_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module hhls_out_stage import hhls_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          produce_i,
  input  result_t       result_i,
  output logic          free_o,
  hhls_result_if.source res_o
);

  logic    valid_q;
  result_t data_q;

  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step_i && produce_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && produce_i) begin
      data_q <= result_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.result_kind  = data_q.result_kind;
  assign res_o.line_index   = data_q.line_index;
  assign res_o.line_length  = data_q.line_length;
  assign res_o.colon_found  = data_q.colon_found;
  assign res_o.key_begin    = data_q.key_begin;
  assign res_o.key_end      = data_q.key_end;
  assign res_o.val_begin    = data_q.val_begin;
  assign res_o.val_end      = data_q.val_end;
  assign res_o.header_bytes = data_q.header_bytes;
  assign res_o.no_lines     = data_q.no_lines;
  assign res_o.overflow     = data_q.overflow;

endmodule

### rtl/core/http_header_line_scanner_core.sv
// ----------------------------------------------------------------------------
// http_header_line_scanner_core
// Scans request bytes for header lines and the CR LF CR LF terminator.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i carries one request byte per transfer; start_of_message marks
//   byte zero and clears the scan state. res_o carries a descriptor per
//   line (request line, then header lines split into key and value ranges)
//   and one end result with the header length once the terminator is seen.
//   A line's descriptor comes out on the first byte of the following line.
//   Bytes after the end result are dropped until the next start byte.
//   Throughput: one byte per cycle while the result register is free, set
//   by the single running-state update that each byte makes. A byte is
//   registered in the input register on transfer, then the scanner steps
//   on it and loads the result register, which drives res_o.
//   Stall: while the result register is full and not taken the scanner
//   holds, the input register keeps one byte, and byte_i.ready drops.
//   Reset: all state cleared, both registers empty.
// ----------------------------------------------------------------------------
module http_header_line_scanner_core import hhls_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  hhls_byte_if.sink     byte_i,
  hhls_result_if.source res_o
);

  logic         item_valid;
  in_item_t     item;
  logic         out_free;
  logic         step;
  logic         produce;
  result_t      result;
  scan_status_t status;

  assign step = item_valid && out_free;

  hhls_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .step_i       (step),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  hhls_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (item),
    .produce_o (produce),
    .result_o  (result),
    .status_o  (status)
  );

  hhls_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .produce_i (produce),
    .result_i  (result),
    .free_o    (out_free),
    .res_o     (res_o)
  );

  a_done_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && produce && result.result_kind == KIND_DONE |=> status.done)
    else $error("end result without done state");

  a_pending_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pending |-> status.skip)
    else $error("held empty line without skip");

  a_request_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind == KIND_REQUEST
      |-> res_o.line_index == '0 && !res_o.colon_found)
    else $error("request line descriptor malformed");

endmodule

### bench/hhls_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhls_line_checker
// Watches the byte and result channels of the header line scanner, runs its
// own scan of every accepted byte and compares each result transfer, field by
// field, with the oldest predicted descriptor or end result.
// ----------------------------------------------------------------------------
module hhls_line_checker import hhls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hhls_byte_if        byte_i,
  hhls_result_if      res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [POS_W-1:0]    byte_pos     = '0;
  logic [TP_W-1:0]     term_prog    = TP_NONE;
  logic [LINE_W-1:0]   line_off     = '0;
  logic [LINENO_W-1:0] line_no      = '0;
  logic                colon_seen   = 1'b0;
  logic [LINE_W-1:0]   key_first    = '0;
  logic [LINE_W-1:0]   key_last     = '0;
  logic [LINE_W-1:0]   val_first    = '0;
  logic [LINE_W-1:0]   val_last     = '0;
  logic                skip_next    = 1'b0;
  logic                held_empty   = 1'b0;
  logic                block_done   = 1'b0;
  logic                sat_seen     = 1'b0;
  logic                emit_due     = 1'b0;

  result_t     descriptor_q[$];
  result_t     predicted;
  result_t     want;
  int unsigned mismatch_count = 0;
  int unsigned backlog        = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = backlog;

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic [31:0] cap);
    if (v < cap) return v + 32'd1;
    sat_seen = 1'b1;
    return cap;
  endfunction

  function automatic void clear_line();
    line_off   = '0;
    colon_seen = 1'b0;
    key_first  = '0;
    key_last   = '0;
    val_first  = '0;
    val_last   = '0;
  endfunction

  function automatic void clear_scan();
    byte_pos   = '0;
    term_prog  = TP_NONE;
    line_no    = '0;
    clear_line();
    skip_next  = 1'b0;
    held_empty = 1'b0;
    block_done = 1'b0;
    sat_seen   = 1'b0;
    emit_due   = 1'b0;
  endfunction

  function automatic result_t line_descriptor();
    result_t           r;
    logic [LINE_W-1:0] len;
    r   = '0;
    len = line_off;
    r.result_kind = (line_no == '0) ? KIND_REQUEST : KIND_HEADER;
    r.line_index  = line_no;
    r.line_length = len;
    if (line_no != '0) begin
      r.colon_found = colon_seen;
      if (colon_seen) begin
        r.key_begin = key_first;
        r.key_end   = key_last;
        if (val_last == '0) begin
          r.val_begin = len;
          r.val_end   = len;
        end else begin
          r.val_begin = val_first;
          r.val_end   = val_last;
        end
      end else begin
        if (key_last == '0) begin
          r.key_begin = len;
          r.key_end   = len;
        end else begin
          r.key_begin = key_first;
          r.key_end   = key_last;
        end
        r.val_begin = len;
        r.val_end   = len;
      end
    end
    line_no = LINENO_W'(sat_inc(32'(line_no), 32'(MAX_LINES)));
    return r;
  endfunction

  function automatic void take_line_byte(input logic [7:0] b);
    logic [LINE_W-1:0] off;
    logic              blank;
    off      = line_off;
    blank    = (b == CH_SPACE) || (b == CH_TAB);
    line_off = LINE_W'(sat_inc(32'(line_off), 32'(MAX_LINE_BYTES)));
    if (!colon_seen) begin
      if (b == CH_COLON) begin
        colon_seen = 1'b1;
        if (key_last == '0) begin
          key_first = off;
          key_last  = off;
        end
      end else if (!blank) begin
        if (key_last == '0) key_first = off;
        key_last = LINE_W'(sat_inc(32'(off), 32'(MAX_LINE_BYTES)));
      end
    end else if (!blank) begin
      if (val_last == '0) val_first = off;
      val_last = LINE_W'(sat_inc(32'(off), 32'(MAX_LINE_BYTES)));
    end
  endfunction

  // one scan step per accepted byte; returns 1 when a result is due
  function automatic logic scan_byte(input logic [7:0] b, input logic som,
                                     output result_t r);
    logic [POS_W-1:0] p;
    logic [TP_W-1:0]  prev;
    logic [7:0]       next_term;
    logic             given;
    r     = '0;
    given = 1'b0;
    if (som) clear_scan();
    if (block_done) return 1'b0;

    p         = byte_pos;
    byte_pos  = POS_W'(sat_inc(32'(byte_pos), 32'(MAX_HEADER_BYTES)));
    prev      = term_prog;
    next_term = prev[0] ? CH_LF : CH_CR;
    if (b == next_term) term_prog = TP_W'(prev + 3'd1);
    else term_prog = (b == CH_CR) ? TP_CR : TP_NONE;

    if (term_prog >= TP_DONE) begin
      block_done     = 1'b1;
      term_prog      = TP_NONE;
      r.result_kind  = KIND_DONE;
      r.header_bytes = POS_W'(sat_inc(32'(p), 32'(MAX_HEADER_BYTES)));
      r.no_lines     = (p == TERM_AT_ZERO_POS);
      r.overflow     = sat_seen;
      return 1'b1;
    end

    if (skip_next) begin
      skip_next = 1'b0;
      if (held_empty) begin
        held_empty = 1'b0;
        r          = line_descriptor();
        given      = 1'b1;
      end
    end else begin
      if (emit_due) begin
        emit_due = 1'b0;
        // empty line that may open the terminator: hold it back
        if (line_off == '0 && prev == TP_CR_LF && b == CH_CR) begin
          held_empty = 1'b1;
        end else begin
          r     = line_descriptor();
          given = 1'b1;
        end
        clear_line();
      end
      if (b == CH_CR) begin
        skip_next = 1'b1;
        emit_due  = 1'b1;
      end else begin
        take_line_byte(b);
      end
    end

    if (given) r.overflow = sat_seen;
    return given;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      descriptor_q.delete();
      backlog = 0;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        if (scan_byte(byte_i.data_byte, byte_i.start_of_message, predicted))
          descriptor_q.push_back(predicted);
      end
      if (res_i.valid && res_i.ready) begin
        if (descriptor_q.size() == 0) begin
          $error("result transfer with nothing awaited: result_kind %0d", res_i.result_kind);
          mismatch_count++;
        end else begin
          want = descriptor_q.pop_front();
          check_field("result_kind",  32'(want.result_kind),  32'(res_i.result_kind));
          check_field("line_index",   32'(want.line_index),   32'(res_i.line_index));
          check_field("line_length",  32'(want.line_length),  32'(res_i.line_length));
          check_field("colon_found",  32'(want.colon_found),  32'(res_i.colon_found));
          check_field("key_begin",    32'(want.key_begin),    32'(res_i.key_begin));
          check_field("key_end",      32'(want.key_end),      32'(res_i.key_end));
          check_field("val_begin",    32'(want.val_begin),    32'(res_i.val_begin));
          check_field("val_end",      32'(want.val_end),      32'(res_i.val_end));
          check_field("header_bytes", 32'(want.header_bytes), 32'(res_i.header_bytes));
          check_field("no_lines",     32'(want.no_lines),     32'(res_i.no_lines));
          check_field("overflow",     32'(want.overflow),     32'(res_i.overflow));
        end
      end
      backlog = descriptor_q.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the header line scanner: directed corner messages, then
// random well-formed, truncated and noisy requests under changing sender and
// receiver idling, a long receiver hold-off, and a message with enough lines
// to drive the line counter into saturation. The checker beside the scanner
// predicts and compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import hhls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        hold_arm        = 1'b0;
  int unsigned sender_idle_pct = 23;
  int unsigned recv_idle_pct   = 70;
  int unsigned cycle_count     = 0;
  int unsigned mismatches;
  int unsigned backlog;
  logic [7:0]  msg_q[$];

  hhls_byte_if   byte_if ();
  hhls_result_if res_if ();

  http_header_line_scanner_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .res_o  (res_if)
  );

  hhls_line_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_if),
    .res_i        (res_if),
    .fail_count_o (mismatches),
    .pending_o    (backlog)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random back-pressure plus one long hold-off once armed
  initial begin
    int unsigned hold_left;
    logic        hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] blank_byte();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] text_byte(input logic allow_colon);
    logic [7:0] c;
    if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
    else c = 8'($urandom_range(8'h7E, 8'h21));
    if (c == CH_CR) c = CH_LF;
    if (!allow_colon && c == CH_COLON) c = 8'h2D;
    return c;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_COLON;
      3:       return CH_SPACE;
      4:       return CH_TAB;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_line(input logic request);
    repeat ($urandom_range(2)) msg_q.push_back(blank_byte());
    repeat ($urandom_range(6)) msg_q.push_back(text_byte(request));
    if (!request) begin
      repeat ($urandom_range(2)) msg_q.push_back(blank_byte());
      if ($urandom_range(99) < 85) begin
        msg_q.push_back(CH_COLON);
        repeat ($urandom_range(2)) msg_q.push_back(blank_byte());
        repeat ($urandom_range(8)) msg_q.push_back(text_byte(1'b1));
        repeat ($urandom_range(2)) msg_q.push_back(blank_byte());
      end
    end
    msg_q.push_back(CH_CR);
    msg_q.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : CH_LF);
  endfunction

  // mostly well-formed requests; some truncated, some pure noise
  function automatic void make_request();
    int unsigned roll;
    int unsigned cut;
    msg_q.delete();
    roll = $urandom_range(99);
    if (roll < 10) begin
      repeat ($urandom_range(30, 1)) msg_q.push_back(noise_byte());
      return;
    end
    add_line(1'b1);
    repeat ($urandom_range(6)) add_line(1'b0);
    msg_q.push_back(CH_CR);
    msg_q.push_back(CH_LF);
    if (roll < 20) begin
      cut   = $urandom_range(msg_q.size() - 1);
      msg_q = msg_q[0:cut];
    end else if (roll < 35) begin
      repeat ($urandom_range(3, 1)) msg_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic som);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid            <= 1'b1;
    byte_if.data_byte        <= b;
    byte_if.start_of_message <= som;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
  endtask

  task automatic send_message();
    int unsigned i;
    for (i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == 0);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    sent = 0;
    while (sent < target) begin
      make_request();
      sent += msg_q.size();
      send_message();
    end
  endtask

  // sender quiet until every predicted result has been taken
  task automatic drain();
    byte_if.valid <= 1'b0;
    do @(negedge clk_i); while (backlog != 0);
    @(posedge clk_i);
  endtask

  initial begin
    byte_if.valid            = 1'b0;
    byte_if.data_byte        = 8'h00;
    byte_if.start_of_message = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // terminator at byte zero
    msg_q = '{CH_CR, CH_LF, CH_CR, CH_LF};
    send_message();
    // skipped non-LF byte, held empty line given, blank key, 00/FF bytes, no-colon line
    msg_q = '{8'h52, CH_CR, 8'h58, CH_CR, CH_LF, CH_CR, 8'h00, CH_TAB, CH_COLON,
              8'hFF, CH_SPACE, CH_CR, CH_LF, 8'h6B, CH_CR, CH_LF, CH_CR, CH_LF};
    send_message();
    // held empty line dropped by the terminator
    msg_q = '{8'h52, CH_CR, 8'h58, CH_CR, CH_LF, CH_CR, CH_LF};
    send_message();

    run_random(450);
    drain();

    sender_idle_pct = 70;
    recv_idle_pct  <= 23;
    hold_arm       <= 1'b1;
    run_random(450);
    drain();

    sender_idle_pct = 0;
    recv_idle_pct  <= 0;
    run_random(450);

    // line number saturation: empty lines, each ended by CR and a skipped byte
    msg_q = '{8'h52, CH_CR, CH_LF};
    repeat (260) begin
      msg_q.push_back(CH_CR);
      msg_q.push_back(8'h78);
    end
    msg_q.push_back(CH_CR);
    msg_q.push_back(CH_LF);
    msg_q.push_back(CH_CR);
    msg_q.push_back(CH_LF);
    send_message();

    drain();
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
